// File: src/cmr_pkg.sv
// ----------------------------------------------------------------------------
// cmr_pkg: shared types and constants for the midpoint circle raster unit
// Function codes, octant type and the octant-to-sign/swap table.
// ----------------------------------------------------------------------------
package cmr_pkg;

	// input field width of center and radius, output pixel width
	localparam int IN_W  = 10;
	localparam int PIX_W = 12;

	// function code carried with each input item
	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_STEP  = 1'b1
	} func_e_t;

	typedef logic [2:0] octant_t;

	localparam octant_t OCT_FIRST = 3'd0;
	localparam octant_t OCT_LAST  = 3'd7;

	// how one octant is built from (x, y): swap the pair, then negate each side
	typedef struct packed {
		logic swap;
		logic neg_x;
		logic neg_y;
	} oct_sel_t;

	function automatic oct_sel_t oct_map(input octant_t oct);
		oct_sel_t s;
		s = '0;
		unique case (oct)
			3'd0: s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
			3'd1: s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
			3'd2: s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
			3'd3: s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
			3'd4: s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
			3'd5: s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
			3'd6: s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
			3'd7: s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// File: src/cmr_walker.sv
// ----------------------------------------------------------------------------
// cmr_walker: input register and midpoint walk state
// Holds one input item, applies start or step to the walk registers and
// hands each active step (old x, y, center, done) to the emitter.
// ----------------------------------------------------------------------------
module cmr_walker #(
	parameter int COORD_BITS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input item
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic                         s_func,
	input  logic [cmr_pkg::IN_W-1:0]     s_cx,
	input  logic [cmr_pkg::IN_W-1:0]     s_cy,
	input  logic [cmr_pkg::IN_W-1:0]     s_r,
	// step record to the emitter
	output logic                         rec_valid,
	input  logic                         rec_ready,
	output logic [COORD_BITS:0]          rec_x,
	output logic [COORD_BITS:0]          rec_y,
	output logic [COORD_BITS-1:0]        rec_cx,
	output logic [COORD_BITS-1:0]        rec_cy,
	output logic                         rec_done
);

	localparam int FW = cmr_pkg::IN_W;
	localparam int WW = (COORD_BITS > FW) ? COORD_BITS : FW;
	localparam int DW = COORD_BITS + 3;

	// input register
	logic                in_vld_s1;
	logic                func_s1;
	logic [FW-1:0]       cx_s1;
	logic [FW-1:0]       cy_s1;
	logic [FW-1:0]       r_s1;

	// walk state
	logic [COORD_BITS-1:0] cent_x_q;
	logic [COORD_BITS-1:0] cent_y_q;
	logic [COORD_BITS:0]   pos_x_q;
	logic [COORD_BITS:0]   pos_y_q;
	logic signed [DW-1:0]  decision_q;
	logic                  active_q;

	logic                  is_start;
	logic                  take;
	logic [WW-1:0]         cx_w;
	logic [WW-1:0]         cy_w;
	logic [WW-1:0]         r_w;
	logic signed [DW-1:0]  x1;
	logic signed [DW-1:0]  y1;
	logic signed [DW-1:0]  dec_nxt;
	logic                  step_done;

	// consume the held item when start, idle step, or the emitter takes the step
	assign is_start  = (func_s1 == cmr_pkg::FUNC_START);
	assign take      = in_vld_s1 && (is_start || !active_q || rec_ready);
	assign s_tready  = !in_vld_s1 || take;
	assign rec_valid = in_vld_s1 && !is_start && active_q;

	// field width to coordinate width
	assign cx_w = WW'(cx_s1);
	assign cy_w = WW'(cy_s1);
	assign r_w  = WW'(r_s1);

	// midpoint rule on the current position
	always_comb begin
		x1 = DW'(pos_x_q) + DW'(1);
		y1 = DW'(pos_y_q);
		if (decision_q < 0) begin
			dec_nxt = decision_q + (x1 <<< 1) + DW'(1);
		end else begin
			y1      = DW'(pos_y_q) - DW'(1);
			dec_nxt = decision_q + (x1 <<< 1) - (y1 <<< 1) + DW'(1);
		end
		step_done = (x1 > y1);
	end

	assign rec_x    = pos_x_q;
	assign rec_y    = pos_y_q;
	assign rec_cx   = cent_x_q;
	assign rec_cy   = cent_y_q;
	assign rec_done = step_done;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			in_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= s_func;
			cx_s1   <= s_cx;
			cy_s1   <= s_cy;
			r_s1    <= s_r;
		end
	end

	// walk state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cent_x_q   <= '0;
			cent_y_q   <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			decision_q <= '0;
			active_q   <= 1'b0;
		end else if (take) begin
			if (is_start) begin
				cent_x_q   <= cx_w[COORD_BITS-1:0];
				cent_y_q   <= cy_w[COORD_BITS-1:0];
				pos_x_q    <= '0;
				pos_y_q    <= (COORD_BITS+1)'(r_w[COORD_BITS-1:0]);
				decision_q <= DW'(1) - DW'(r_w[COORD_BITS-1:0]);
				active_q   <= 1'b1;
			end else if (active_q) begin
				pos_x_q    <= x1[COORD_BITS:0];
				pos_y_q    <= y1[COORD_BITS:0];
				decision_q <= dec_nxt;
				active_q   <= !step_done;
			end
		end
	end

	// a finishing step leaves the walk idle
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready && rec_done |=> !active_q)
		else $error("walk still active after final step");

	// a start always arms the walk
	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_start |=> active_q && pos_x_q == '0)
		else $error("start did not arm the walk");

endmodule

// File: src/cmr_emitter.sv
// ----------------------------------------------------------------------------
// cmr_emitter: eight-way symmetric pixel sequencer
// Holds one step record and walks its eight octants into an output
// register, one pixel per cycle while the sink takes them.
// ----------------------------------------------------------------------------
module cmr_emitter #(
	parameter int COORD_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// step record from the walker
	input  logic                          rec_valid,
	output logic                          rec_ready,
	input  logic [COORD_BITS:0]           rec_x,
	input  logic [COORD_BITS:0]           rec_y,
	input  logic [COORD_BITS-1:0]         rec_cx,
	input  logic [COORD_BITS-1:0]         rec_cy,
	input  logic                          rec_done,
	// pixel output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cmr_pkg::PIX_W-1:0]     out_px,
	output logic [cmr_pkg::PIX_W-1:0]     out_py,
	output cmr_pkg::octant_t              out_oct,
	output logic                          out_last,
	output logic                          out_done
);

	localparam int PW = cmr_pkg::PIX_W;
	localparam int EW = (COORD_BITS + 1 > PW) ? COORD_BITS + 1 : PW;

	// step record
	logic                  busy_q;
	cmr_pkg::octant_t      oct_q;
	logic [COORD_BITS:0]   x_q;
	logic [COORD_BITS:0]   y_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic                  done_q;

	// output register
	logic                  out_vld_q;
	logic [PW-1:0]         px_q;
	logic [PW-1:0]         py_q;
	cmr_pkg::octant_t      oct_out_q;
	logic                  last_q;
	logic                  done_out_q;

	logic                  adv;
	logic                  load;
	logic [EW-1:0]         x_e;
	logic [EW-1:0]         y_e;
	logic [EW-1:0]         cx_e;
	logic [EW-1:0]         cy_e;
	logic [PW-1:0]         a12;
	logic [PW-1:0]         b12;
	logic [PW-1:0]         px_nxt;
	logic [PW-1:0]         py_nxt;
	cmr_pkg::oct_sel_t     sel;

	// move one pixel into the output register when it is free or draining
	assign adv       = busy_q && (!out_vld_q || out_ready);
	assign rec_ready = !busy_q || (adv && oct_q == cmr_pkg::OCT_LAST);
	assign load      = rec_valid && rec_ready;

	// pixel of the current octant, modulo 2^PIX_W
	assign x_e  = EW'(x_q);
	assign y_e  = EW'(y_q);
	assign cx_e = EW'(cx_q);
	assign cy_e = EW'(cy_q);
	assign sel  = cmr_pkg::oct_map(oct_q);

	always_comb begin
		a12    = sel.swap ? y_e[PW-1:0] : x_e[PW-1:0];
		b12    = sel.swap ? x_e[PW-1:0] : y_e[PW-1:0];
		px_nxt = sel.neg_x ? (cx_e[PW-1:0] - a12) : (cx_e[PW-1:0] + a12);
		py_nxt = sel.neg_y ? (cy_e[PW-1:0] - b12) : (cy_e[PW-1:0] + b12);
	end

	// record control and octant counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			oct_q  <= cmr_pkg::OCT_FIRST;
		end else if (load) begin
			busy_q <= 1'b1;
			oct_q  <= cmr_pkg::OCT_FIRST;
		end else if (adv) begin
			oct_q <= oct_q + 3'd1;
			if (oct_q == cmr_pkg::OCT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= rec_x;
			y_q    <= rec_y;
			cx_q   <= rec_cx;
			cy_q   <= rec_cy;
			done_q <= rec_done;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q       <= px_nxt;
			py_q       <= py_nxt;
			oct_out_q  <= oct_q;
			last_q     <= (oct_q == cmr_pkg::OCT_LAST);
			done_out_q <= done_q;
		end
	end

	assign out_valid = out_vld_q;
	assign out_px    = px_q;
	assign out_py    = py_q;
	assign out_oct   = oct_out_q;
	assign out_last  = last_q;
	assign out_done  = done_out_q;

	// only the eighth pixel of a step is marked last
	a_last_oct: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (last_q == (oct_out_q == cmr_pkg::OCT_LAST)))
		else $error("last flag does not match octant");

	// a pixel short of the eighth leaves the record busy
	a_rest_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && oct_out_q != cmr_pkg::OCT_LAST |-> busy_q)
		else $error("step record freed before all octants sent");

	// the octant counter follows the pixel just registered
	a_oct_follow: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !load |=> oct_q == $past(oct_q) + 3'd1)
		else $error("octant counter skipped");

endmodule

// File: src/midpoint_circle_raster_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_raster_unit: midpoint circle rasterizer, eight-way symmetry
// A start item loads center and radius; each step item of an active walk
// emits the eight symmetric pixels of the current point and advances the walk.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                               tuser              tlast
//  s_*      in   center_x, center_y, radius          func               -
//  m_*      out  pixel_x, pixel_y                    octant, done_res   last
//
//  A start or an idle step emits nothing.
//  An active step emits eight pixels, one per cycle while m_tready is high;
//  the first passes the input register, step record and output register.
//  The next item is held in the input register while pixels drain.
//  Reset clears the walk to idle with zero center and position.
//  Back pressure on m_tready stalls the octant sequencer, then the input.
// ----------------------------------------------------------------------------
module midpoint_circle_raster_unit #(
	parameter int COORD_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [9:0] center_x, [19:10] center_y, [29:20] radius
	input  logic [0:0]  s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [11:0] pixel_x, [23:12] pixel_y
	output logic [3:0]  m_tuser,   // [2:0] octant, [3] done_res
	output logic        m_tlast
);

	localparam int FW = cmr_pkg::IN_W;
	localparam int PW = cmr_pkg::PIX_W;

	logic                  rec_valid;
	logic                  rec_ready;
	logic [COORD_BITS:0]   rec_x;
	logic [COORD_BITS:0]   rec_y;
	logic [COORD_BITS-1:0] rec_cx;
	logic [COORD_BITS-1:0] rec_cy;
	logic                  rec_done;
	logic [PW-1:0]         px;
	logic [PW-1:0]         py;
	cmr_pkg::octant_t      oct;
	logic                  done_res;

	// walk state and input register
	cmr_walker #(
		.COORD_BITS (COORD_BITS)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_func    (s_tuser[0]),
		.s_cx      (s_tdata[FW-1:0]),
		.s_cy      (s_tdata[2*FW-1:FW]),
		.s_r       (s_tdata[3*FW-1:2*FW]),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec_x     (rec_x),
		.rec_y     (rec_y),
		.rec_cx    (rec_cx),
		.rec_cy    (rec_cy),
		.rec_done  (rec_done)
	);

	// octant sequencer and output register
	cmr_emitter #(
		.COORD_BITS (COORD_BITS)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec_x     (rec_x),
		.rec_y     (rec_y),
		.rec_cx    (rec_cx),
		.rec_cy    (rec_cy),
		.rec_done  (rec_done),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_px    (px),
		.out_py    (py),
		.out_oct   (oct),
		.out_last  (m_tlast),
		.out_done  (done_res)
	);

	// output packing
	assign m_tdata = {py, px};
	assign m_tuser = {done_res, oct};

endmodule
